// ===== hdl/sdpa_pkg.sv =====
// sdpa_pkg: shared types and constants for the attention row core
// beat structs, sequencer states, register indexes, status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sdpa_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_DIM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAUSAL_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_SCALE = 2'd3;

  localparam logic [8:0]  KEY_COUNT_RST   = 9'd256;
  localparam logic [6:0]  HEAD_DIM_RST    = 7'd64;
  localparam logic        CAUSAL_MODE_RST = 1'b1;
  localparam logic [15:0] SCORE_SCALE_RST = 16'd8192;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_MASKED = 2'd1;
  localparam logic [1:0] STAT_SAT    = 2'd2;

  // log2(e) in Q.16, ln(2) in Q.32
  localparam logic [31:0] LOG2E_Q16 = 32'd94548;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  // shared multiplier operand widths
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         key_slot;
    logic [5:0]         feature_index;
    logic signed [15:0] key_element;
    logic signed [15:0] value_element;
    logic [31:0]        key_position;
    logic signed [15:0] query_element;
    logic [31:0]        query_position;
    logic               last_feature;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] context_element;
    logic [5:0]         out_feature;
    logic [1:0]         status;
    logic               last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_DOT,
    ST_SC_MUL,
    ST_SC_RND,
    ST_SC_END,
    ST_WT_RD,
    ST_WT_CHK,
    ST_WT_IDX,
    ST_WT_TAB,
    ST_WT_W,
    ST_WT_DIV,
    ST_CT_RUN,
    ST_CT_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/scaled_dot_product_attention_row_core.sv =====
// scaled_dot_product_attention_row_core: one-query-row attention with causal mask
// depends on sdpa_pkg, sdpa_ram, sdpa_mul, sdpa_div
//
//   channel  | signals                        | direction | beat
//   in       | in_valid in_stall in_data      | input     | store or query element
//   out      | out_valid out_stall out_data   | output    | one context element
//   cfg      | cfg_we cfg_index cfg_data      | input     | register write
//
// store beats and query beats without last_feature are taken whenever the core is idle.
// a row's length grows with the keys in use and the features, set by the one
// shared multiplier and the bit-serial divider per key.
// in_stall is high for the whole row; a finished context beat waits in the
// output register while the next feature is being summed.
// reset (rst, synchronous) sets the control registers only; stores hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module scaled_dot_product_attention_row_core #(
  parameter int MAX_KEYS        = 256,
  parameter int MAX_HEAD_DIM    = 64,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire sdpa_pkg::in_item_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      sdpa_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_we,
  input  wire logic [sdpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sdpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int DW    = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;
  localparam int TW    = $clog2(EXP_TABLE_DEPTH);
  localparam int KCW   = $clog2(MAX_KEYS + 1);
  localparam int HDW   = $clog2(MAX_HEAD_DIM + 1);
  localparam int DEN_W = KW + 18;
  localparam int NUM_W = (DEN_W > 33) ? DEN_W + 1 : 34;
  localparam int Q_W   = 18;
  localparam int A_W   = sdpa_pkg::MUL_A_W;
  localparam int B_W   = sdpa_pkg::MUL_B_W;
  localparam int P_W   = sdpa_pkg::MUL_P_W;

  // exp table, built at elaboration
  function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
    case (k)
      2:       return v / 2;
      3:       return v / 3;
      4:       return v / 4;
      5:       return v / 5;
      6:       return v / 6;
      7:       return v / 7;
      8:       return v / 8;
      9:       return v / 9;
      10:      return v / 10;
      11:      return v / 11;
      12:      return v / 12;
      13:      return v / 13;
      14:      return v / 14;
      default: return v;
    endcase
  endfunction

  function automatic logic [16:0] exp_entry(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    x    = (j * 64'(sdpa_pkg::LN2_Q32)) / EXP_TABLE_DEPTH;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int k = 1; k <= 14; k++) begin
      term = div_small((term * x) >> 32, k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return 17'((64'(sum) + 64'd32768) >> 16);
  endfunction

  logic [16:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [16:0] ENTRY = exp_entry(64'(g));
    assign exp_rom[g] = ENTRY;
  end

  sdpa_pkg::state_t state, state_next;

  logic [8:0]  key_count;
  logic [6:0]  head_dim;
  logic        causal_mode;
  logic [15:0] score_scale;

  logic [KCW-1:0]     kc, c;
  logic [HDW-1:0]     hd, f;
  logic [31:0]        qpos;
  logic               any, row_sat, prob;
  logic signed [31:0] maxv;
  logic signed [39:0] dot;
  logic [DEN_W-1:0]   den;
  logic signed [47:0] acc;
  logic               n_big;
  logic [4:0]         n_sh;
  logic               rd_v, mul_v;
  logic [16:0]        exp_q;

  logic [15:0] q_rdata, k_rdata, v_rdata;
  logic [31:0] pos_rdata;
  logic [32:0] sc_rdata;
  logic        sc_we;
  logic [32:0] sc_wdata;

  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_p;

  logic             div_start, div_done;
  logic [Q_W-1:0]   quot;
  logic [NUM_W-1:0] div_num;

  // input side
  logic in_acc, slot_ok, feat_ok, st_wr, kv_wr, q_wr, row_go;
  logic [KW+DW-1:0] kv_waddr;

  assign in_stall = (state != sdpa_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = int'(in_data.key_slot) < MAX_KEYS;
  assign feat_ok  = int'(in_data.feature_index) < MAX_HEAD_DIM;
  assign st_wr    = in_acc && (in_data.req_type == sdpa_pkg::REQ_STORE) && slot_ok;
  assign kv_wr    = st_wr && feat_ok;
  assign q_wr     = in_acc && (in_data.req_type == sdpa_pkg::REQ_QUERY) && feat_ok;
  assign row_go   = in_acc && (in_data.req_type == sdpa_pkg::REQ_QUERY) && in_data.last_feature;
  assign kv_waddr = {KW'(in_data.key_slot), DW'(in_data.feature_index)};

  logic [KCW-1:0] kc_eff;
  logic [HDW-1:0] hd_eff;

  assign kc_eff = (int'(key_count) > MAX_KEYS) ? KCW'(MAX_KEYS) : KCW'(key_count);
  assign hd_eff = (head_dim == '0) ? HDW'(1) :
                  (int'(head_dim) > MAX_HEAD_DIM) ? HDW'(MAX_HEAD_DIM) : HDW'(head_dim);

  // stores
  logic [KW+DW-1:0] kv_raddr;
  assign kv_raddr = {c[KW-1:0], f[DW-1:0]};

  sdpa_ram #(.WIDTH(16), .DEPTH(1 << (KW + DW))) u_key_ram (
    .clk(clk), .we(kv_wr), .waddr(kv_waddr), .wdata(in_data.key_element),
    .raddr(kv_raddr), .rdata(k_rdata)
  );

  sdpa_ram #(.WIDTH(16), .DEPTH(1 << (KW + DW))) u_val_ram (
    .clk(clk), .we(kv_wr), .waddr(kv_waddr), .wdata(in_data.value_element),
    .raddr(kv_raddr), .rdata(v_rdata)
  );

  sdpa_ram #(.WIDTH(32), .DEPTH(1 << KW)) u_pos_ram (
    .clk(clk), .we(st_wr), .waddr(KW'(in_data.key_slot)), .wdata(in_data.key_position),
    .raddr(c[KW-1:0]), .rdata(pos_rdata)
  );

  sdpa_ram #(.WIDTH(16), .DEPTH(1 << DW)) u_query_ram (
    .clk(clk), .we(q_wr), .waddr(DW'(in_data.feature_index)), .wdata(in_data.query_element),
    .raddr(f[DW-1:0]), .rdata(q_rdata)
  );

  // bit 32 marks a live key; low bits hold the score, later the probability
  sdpa_ram #(.WIDTH(33), .DEPTH(1 << KW)) u_score_ram (
    .clk(clk), .we(sc_we), .waddr(c[KW-1:0]), .wdata(sc_wdata),
    .raddr(c[KW-1:0]), .rdata(sc_rdata)
  );

  sdpa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  sdpa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(den),
    .done(div_done), .quot(quot)
  );

  // datapath decode
  logic issue, last_key, last_f, masked, live, wt_adv, out_free;
  logic signed [31:0] s_cur, s_new;
  logic signed [33:0] d;
  logic signed [57:0] sc_rnd;
  logic signed [33:0] sc_sh;
  logic               sc_hi, sc_lo;
  logic [16:0]        w;
  logic [TW-1:0]      exp_idx;
  logic [15:0]        p16;
  logic signed [47:0] ct_rnd;
  logic signed [31:0] ct_sh;
  logic               ct_hi, ct_lo, ct_sat;
  logic signed [15:0] ct_val;

  assign issue    = (state == sdpa_pkg::ST_SC_DOT) ? (f < hd) :
                    (state == sdpa_pkg::ST_CT_RUN) ? (c < kc) : 1'b0;
  assign last_key = (c == kc - KCW'(1));
  assign last_f   = (f == hd - HDW'(1));
  assign masked   = causal_mode && (pos_rdata > qpos);
  assign live     = sc_rdata[32];
  assign s_cur    = sc_rdata[31:0];
  assign d        = 34'(maxv) - 34'(s_cur);

  // round(dot * scale / 2^24), saturated to 32 bits
  assign sc_rnd = mul_p + 58'sd8388608;
  assign sc_sh  = sc_rnd[57:24];
  assign sc_hi  = sc_sh > 34'sd2147483647;
  assign sc_lo  = sc_sh < -34'sd2147483648;
  assign s_new  = sc_hi ? 32'h7fff_ffff : sc_lo ? 32'h8000_0000 : sc_sh[31:0];

  assign exp_idx = mul_p[TW+15:16];
  assign w       = n_big ? 17'd0 : (exp_q >> n_sh);
  assign div_num = NUM_W'({w, 16'd0}) + NUM_W'(den >> 1);
  assign p16     = (quot[Q_W-1:16] != '0) ? 16'hffff : quot[15:0];

  assign wt_adv = ((state == sdpa_pkg::ST_WT_CHK) && !live) ||
                  ((state == sdpa_pkg::ST_WT_W) && !prob) ||
                  ((state == sdpa_pkg::ST_WT_DIV) && div_done);

  assign ct_rnd = acc + 48'sd32768;
  assign ct_sh  = ct_rnd[47:16];
  assign ct_hi  = ct_sh > 32'sd32767;
  assign ct_lo  = ct_sh < -32'sd32768;
  assign ct_sat = any && (ct_hi || ct_lo);
  assign ct_val = !any ? 16'sd0 : ct_hi ? 16'sh7fff : ct_lo ? 16'sh8000 : ct_sh[15:0];

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdpa_pkg::ST_IDLE:   if (row_go) begin
        state_next = (kc_eff == '0) ? sdpa_pkg::ST_SC_END : sdpa_pkg::ST_SC_RD;
      end
      sdpa_pkg::ST_SC_RD:  state_next = sdpa_pkg::ST_SC_CHK;
      sdpa_pkg::ST_SC_CHK: begin
        if (!masked)       state_next = sdpa_pkg::ST_SC_DOT;
        else if (last_key) state_next = sdpa_pkg::ST_SC_END;
        else               state_next = sdpa_pkg::ST_SC_RD;
      end
      sdpa_pkg::ST_SC_DOT: if (!issue && !rd_v && !mul_v) begin
        state_next = sdpa_pkg::ST_SC_MUL;
      end
      sdpa_pkg::ST_SC_MUL: state_next = sdpa_pkg::ST_SC_RND;
      sdpa_pkg::ST_SC_RND: state_next = last_key ? sdpa_pkg::ST_SC_END : sdpa_pkg::ST_SC_RD;
      sdpa_pkg::ST_SC_END: state_next = any ? sdpa_pkg::ST_WT_RD : sdpa_pkg::ST_CT_OUT;
      sdpa_pkg::ST_WT_RD:  state_next = sdpa_pkg::ST_WT_CHK;
      sdpa_pkg::ST_WT_CHK: if (live) state_next = sdpa_pkg::ST_WT_IDX;
      sdpa_pkg::ST_WT_IDX: state_next = sdpa_pkg::ST_WT_TAB;
      sdpa_pkg::ST_WT_TAB: state_next = sdpa_pkg::ST_WT_W;
      sdpa_pkg::ST_WT_W:   if (prob) state_next = sdpa_pkg::ST_WT_DIV;
      sdpa_pkg::ST_WT_DIV: ;
      sdpa_pkg::ST_CT_RUN: if (!issue && !rd_v && !mul_v) begin
        state_next = sdpa_pkg::ST_CT_OUT;
      end
      sdpa_pkg::ST_CT_OUT: if (out_free) begin
        if (last_f)   state_next = sdpa_pkg::ST_IDLE;
        else if (any) state_next = sdpa_pkg::ST_CT_RUN;
      end
      default: state_next = sdpa_pkg::ST_IDLE;
    endcase
    // end of a weight step: next key, next pass, or on to the context sums
    if (wt_adv) begin
      state_next = (last_key && prob) ? sdpa_pkg::ST_CT_RUN : sdpa_pkg::ST_WT_RD;
    end
  end

  // unit operands and score writes
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    sc_we     = 1'b0;
    sc_wdata  = '0;
    div_start = 1'b0;
    case (state)
      sdpa_pkg::ST_SC_CHK: sc_we = masked;
      sdpa_pkg::ST_SC_DOT: begin
        mul_a = A_W'($signed(q_rdata));
        mul_b = B_W'($signed(k_rdata));
      end
      sdpa_pkg::ST_SC_MUL: begin
        mul_a = dot;
        mul_b = B_W'(score_scale);
      end
      sdpa_pkg::ST_SC_RND: begin
        sc_we    = 1'b1;
        sc_wdata = {1'b1, s_new};
      end
      sdpa_pkg::ST_WT_CHK: begin
        mul_a = A_W'(d);
        mul_b = B_W'(sdpa_pkg::LOG2E_Q16);
        sc_we = prob && !live;
      end
      sdpa_pkg::ST_WT_IDX: begin
        mul_a = A_W'(mul_p[31:16]);
        mul_b = B_W'(EXP_TABLE_DEPTH);
      end
      sdpa_pkg::ST_WT_W:   div_start = prob;
      sdpa_pkg::ST_WT_DIV: begin
        sc_we    = div_done;
        sc_wdata = {1'b1, 16'd0, p16};
      end
      sdpa_pkg::ST_CT_RUN: begin
        mul_a = A_W'($signed(v_rdata));
        mul_b = B_W'(sc_rdata[15:0]);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sdpa_pkg::ST_IDLE;
      key_count   <= sdpa_pkg::KEY_COUNT_RST;
      head_dim    <= sdpa_pkg::HEAD_DIM_RST;
      causal_mode <= sdpa_pkg::CAUSAL_MODE_RST;
      score_scale <= sdpa_pkg::SCORE_SCALE_RST;
      rd_v        <= 1'b0;
      mul_v       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      mul_v <= rd_v;
      if (cfg_we) begin
        case (cfg_index)
          sdpa_pkg::REG_KEY_COUNT:   key_count   <= cfg_data[8:0];
          sdpa_pkg::REG_HEAD_DIM:    head_dim    <= cfg_data[6:0];
          sdpa_pkg::REG_CAUSAL_MODE: causal_mode <= cfg_data[0];
          sdpa_pkg::REG_SCORE_SCALE: score_scale <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == sdpa_pkg::ST_CT_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      sdpa_pkg::ST_IDLE: if (row_go) begin
        qpos    <= in_data.query_position;
        kc      <= kc_eff;
        hd      <= hd_eff;
        c       <= '0;
        f       <= '0;
        any     <= 1'b0;
        row_sat <= 1'b0;
        maxv    <= '0;
      end
      sdpa_pkg::ST_SC_CHK: begin
        if (masked) begin
          c <= c + KCW'(1);
        end else begin
          f   <= '0;
          dot <= '0;
        end
      end
      sdpa_pkg::ST_SC_DOT: begin
        if (issue) f <= f + HDW'(1);
        if (mul_v) dot <= dot + mul_p[39:0];
      end
      sdpa_pkg::ST_SC_RND: begin
        if (!any || s_new > maxv) maxv <= s_new;
        any <= 1'b1;
        if (sc_hi || sc_lo) row_sat <= 1'b1;
        c <= c + KCW'(1);
      end
      sdpa_pkg::ST_SC_END: begin
        c    <= '0;
        f    <= '0;
        den  <= '0;
        prob <= 1'b0;
      end
      sdpa_pkg::ST_WT_IDX: begin
        n_big <= (mul_p[50:37] != '0);
        n_sh  <= mul_p[36:32];
      end
      sdpa_pkg::ST_WT_W: if (!prob) den <= den + DEN_W'(w);
      sdpa_pkg::ST_CT_RUN: begin
        if (issue) c <= c + KCW'(1);
        if (mul_v) acc <= acc + mul_p[47:0];
      end
      sdpa_pkg::ST_CT_OUT: if (out_free) begin
        f   <= f + HDW'(1);
        c   <= '0;
        acc <= '0;
      end
      default: ;
    endcase
    if (wt_adv) begin
      if (last_key) begin
        c <= '0;
        if (prob) begin
          f   <= '0;
          acc <= '0;
        end else begin
          prob <= 1'b1;
        end
      end else begin
        c <= c + KCW'(1);
      end
    end
    exp_q <= exp_rom[exp_idx];
    if (state == sdpa_pkg::ST_CT_OUT && out_free) begin
      out_data.context_element <= ct_val;
      out_data.out_feature     <= 6'(f);
      out_data.status          <= !any ? sdpa_pkg::STAT_MASKED :
                                  (row_sat || ct_sat) ? sdpa_pkg::STAT_SAT : sdpa_pkg::STAT_OK;
      out_data.last_result     <= last_f;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sdpa_ram.sv =====
// sdpa_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sdpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [ADDR_W-1:0]         raddr,
  output      logic [WIDTH-1:0]          rdata
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/sdpa_mul.sv =====
// sdpa_mul: shared signed multiplier with registered product
// depends on sdpa_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none
module sdpa_mul (
  input  wire logic                                 clk,
  input  wire logic signed [sdpa_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [sdpa_pkg::MUL_B_W-1:0]  b,
  output      logic signed [sdpa_pkg::MUL_P_W-1:0]  p
);
  always_ff @(posedge clk) begin
    p <= sdpa_pkg::MUL_P_W'(a) * sdpa_pkg::MUL_P_W'(b);
  end
endmodule
`default_nettype wire

// ===== hdl/sdpa_div.sv =====
// sdpa_div: restoring unsigned divider, one quotient bit per cycle
// quotient must fit Q_W bits; no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module sdpa_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 26,
  parameter int Q_W   = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output      logic             done,
  output      logic [Q_W-1:0]   quot
);
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int SW = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic          busy;
  logic [CW-1:0] rem;
  logic [CW-1:0] dsh;
  logic [SW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= CW'(num);
      dsh  <= CW'(den) << (Q_W - 1);
      quot <= '0;
      cnt  <= SW'(Q_W - 1);
    end else if (busy) begin
      if (rem >= dsh) begin
        rem       <= rem - dsh;
        quot[cnt] <= 1'b1;
      end
      dsh <= dsh >> 1;
      if (cnt != '0) begin
        cnt <= cnt - SW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_scaled_dot_product_attention_row_core.sv =====
// testbench for scaled_dot_product_attention_row_core: stores, query rows, context beats
// depends on sdpa_pkg and the core; predicts every context beat and checks it in order
`timescale 1ns / 1ps
`default_nettype none
module tb_scaled_dot_product_attention_row_core;
  import sdpa_pkg::*;

  localparam int NKEYS = 256;
  localparam int NFEAT = 64;
  localparam int TAB_DEPTH = 1024;
  localparam int STALL_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scaled_dot_product_attention_row_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] key_mem [NKEYS][NFEAT];
  logic signed [15:0] val_mem [NKEYS][NFEAT];
  logic [31:0] pos_mem [NKEYS];
  logic signed [15:0] query_mem [NFEAT];
  bit kv_written [NKEYS][NFEAT];
  longint unsigned exp_tab [TAB_DEPTH];
  logic [8:0] kc_reg = KEY_COUNT_RST;
  logic [6:0] hd_reg = HEAD_DIM_RST;
  logic causal_reg = CAUSAL_MODE_RST;
  logic [15:0] scale_reg = SCORE_SCALE_RST;

  out_item_t context_expected[$];
  int errors = 0;
  int beats_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned exp_entry(int j);
    longint unsigned x, term;
    longint sum;
    x = (longint'(j) * longint'(LN2_Q32)) / TAB_DEPTH;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * x) >> 32) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return (longint'(sum) + 32768) >> 16;
  endfunction

  function automatic longint unsigned exp_weight(longint unsigned d);
    longint unsigned u, n, idx;
    u = (d * longint'(LOG2E_Q16)) >> 16;
    n = u >> 16;
    idx = ((u & 64'hFFFF) * TAB_DEPTH) >> 16;
    if (n >= 32) return 0;
    return exp_tab[idx] >> n;
  endfunction

  // scores, masks, softmax and weighted value sums for one query row
  function automatic void predict_row(logic [31:0] qpos);
    int kc, hd;
    longint score [NKEYS];
    bit live [NKEYS];
    bit any, row_sat, sat;
    longint maxv, dot, s, v;
    longint unsigned den, w, p;
    longint acc [NFEAT];
    out_item_t e;
    kc = (kc_reg > NKEYS) ? NKEYS : kc_reg;
    hd = (hd_reg == 0) ? 1 : ((hd_reg > NFEAT) ? NFEAT : hd_reg);
    any = 0; row_sat = 0; maxv = 0; den = 0;
    for (int c = 0; c < kc; c++) begin
      live[c] = !(causal_reg && pos_mem[c] > qpos);
      if (!live[c]) continue;
      dot = 0;
      for (int f = 0; f < hd; f++) dot += longint'(query_mem[f]) * longint'(key_mem[c][f]);
      s = (dot * longint'(scale_reg) + (64'sd1 <<< 23)) >>> 24;
      if (s > 64'sd2147483647) begin s = 64'sd2147483647; row_sat = 1; end
      if (s < -64'sd2147483648) begin s = -64'sd2147483648; row_sat = 1; end
      score[c] = s;
      if (!any || s > maxv) maxv = s;
      any = 1;
    end
    for (int f = 0; f < hd; f++) acc[f] = 0;
    if (any) begin
      for (int c = 0; c < kc; c++)
        if (live[c]) den += exp_weight(maxv - score[c]);
      for (int c = 0; c < kc; c++) begin
        if (!live[c]) continue;
        w = exp_weight(maxv - score[c]);
        p = ((w << 16) + den / 2) / den;
        if (p > 65535) p = 65535;
        for (int f = 0; f < hd; f++) acc[f] += longint'(p) * longint'(val_mem[c][f]);
      end
    end
    for (int f = 0; f < hd; f++) begin
      v = any ? ((acc[f] + 32768) >>> 16) : 0;
      sat = 0;
      if (v > 32767) begin v = 32767; sat = 1; end
      if (v < -32768) begin v = -32768; sat = 1; end
      e.context_element = v[15:0];
      e.out_feature = f[5:0];
      e.status = !any ? STAT_MASKED : ((row_sat || sat) ? STAT_SAT : STAT_OK);
      e.last_result = (f == hd - 1);
      context_expected.push_back(e);
    end
  endfunction

  function automatic void absorb_beat(in_item_t b);
    if (b.req_type == REQ_STORE) begin
      pos_mem[b.key_slot] = b.key_position;
      key_mem[b.key_slot][b.feature_index] = b.key_element;
      val_mem[b.key_slot][b.feature_index] = b.value_element;
      kv_written[b.key_slot][b.feature_index] = 1;
    end else begin
      query_mem[b.feature_index] = b.query_element;
      if (b.last_feature) predict_row(b.query_position);
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // output beat checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (context_expected.size() == 0) begin
        report("unexpected beat, feature", out_data.out_feature, -1);
      end else begin
        e = context_expected.pop_front();
        if (out_data.context_element !== e.context_element)
          report("context_element", out_data.context_element, e.context_element);
        if (out_data.out_feature !== e.out_feature)
          report("out_feature", out_data.out_feature, e.out_feature);
        if (out_data.status !== e.status) report("status", out_data.status, e.status);
        if (out_data.last_result !== e.last_result)
          report("last_result", out_data.last_result, e.last_result);
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles with no beat moving on any port
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_scaled_dot_product_attention_row_core: FAIL");
      $finish;
    end
  end

  task automatic send_beat(in_item_t b);
    bit taken;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data <= in_item_t'({$urandom, $urandom, $urandom, $urandom});
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    absorb_beat(b);
    beats_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    release_input();
    while (context_expected.size() != 0) @(posedge clk);
  endtask

  // drain plus the tail of a row so the core is idle before a register write
  task automatic wait_idle();
    wait_drain();
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_COUNT:   kc_reg = data[8:0];
      REG_HEAD_DIM:    hd_reg = data[6:0];
      REG_CAUSAL_MODE: causal_reg = data[0];
      default:         scale_reg = data;
    endcase
  endtask

  task automatic configure(int kc, int hd, bit causal, int scale);
    wait_idle();
    write_reg(REG_KEY_COUNT, 16'(kc) | (16'($urandom) & 16'hFE00));
    write_reg(REG_HEAD_DIM, 16'(hd) | (16'($urandom) & 16'hFF80));
    write_reg(REG_CAUSAL_MODE, 16'(causal) | (16'($urandom) & 16'hFFFE));
    write_reg(REG_SCORE_SCALE, 16'(scale));
  endtask

  function automatic in_item_t store_item(int slot, int feat, logic [31:0] pos,
                                          logic [15:0] kval, logic [15:0] vval);
    in_item_t b;
    b = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    b.req_type = REQ_STORE;
    b.key_slot = slot[7:0];
    b.feature_index = feat[5:0];
    b.key_position = pos;
    b.key_element = kval;
    b.value_element = vval;
    return b;
  endfunction

  function automatic in_item_t query_item(int feat, logic [31:0] qpos, logic [15:0] qval,
                                          bit last);
    in_item_t b;
    b = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    b.req_type = REQ_QUERY;
    b.feature_index = feat[5:0];
    b.query_position = qpos;
    b.query_element = qval;
    b.last_feature = last;
    return b;
  endfunction

  // one query row: fill missing store entries, refresh some, then the query beats.
  // all_masked puts every used key after a query at position zero
  task automatic run_row(bit all_masked, int fixed_elem);
    int kc, hd;
    logic [31:0] qpos, pos;
    logic [15:0] kval, vval, qval;
    kc = (kc_reg > NKEYS) ? NKEYS : kc_reg;
    hd = (hd_reg == 0) ? 1 : ((hd_reg > NFEAT) ? NFEAT : hd_reg);
    qpos = all_masked ? 32'd0 : (($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom);
    for (int c = 0; c < kc; c++)
      for (int f = 0; f < hd; f++)
        if (!kv_written[c][f] || $urandom_range(3) == 0 || (all_masked && f == 0)) begin
          pos = all_masked ? ($urandom | 32'd1) : $urandom;
          kval = (fixed_elem != 0) ? 16'(fixed_elem) : 16'($urandom);
          vval = (fixed_elem != 0) ? 16'(fixed_elem) : 16'($urandom);
          send_beat(store_item(c, f, pos, kval, vval));
        end
    if ($urandom_range(3) == 0)
      send_beat(store_item($urandom_range(255), $urandom_range(63), $urandom,
                           16'($urandom), 16'($urandom)));
    if ($urandom_range(3) == 0)
      send_beat(query_item($urandom_range(63), $urandom, 16'($urandom), 1'b0));
    for (int f = 0; f < hd; f++) begin
      qval = (fixed_elem != 0) ? 16'(fixed_elem) : 16'($urandom);
      send_beat(query_item(f, qpos, qval, f == hd - 1));
    end
  endtask

  task automatic test_directed_extremes();
    configure(2, 3, 1'b0, 65535);
    run_row(1'b0, 32767);
    run_row(1'b0, -32768);
    run_row(1'b0, 0);
    configure(3, 2, 1'b1, 8192);
    run_row(1'b1, 0);
  endtask

  task automatic test_register_corners();
    configure(0, 0, 1'b0, 0);
    run_row(1'b0, 0);
    configure(1, 127, 1'b1, 12345);
    run_row(1'b0, 0);
    configure(511, 1, 1'b1, 4096);
    run_row(1'b1, 0);
    run_row(1'b0, 0);
    configure(256, 1, 1'b0, 65535);
    run_row(1'b0, 0);
  endtask

  task automatic test_random_rows();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 70 : ((ph == 3) ? 9 : 0);
      stall_pct = (ph == 2) ? 70 : ((ph == 3) ? 9 : 0);
      target = beats_sent + 120;
      while (beats_sent < target) begin
        configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6), $urandom_range(1, 8),
                  $urandom_range(1), ($urandom_range(1) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(16384));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(4) == 0) wait_drain();
          run_row($urandom_range(7) == 0, 0);
        end
      end
    end
  endtask

  initial begin
    for (int j = 0; j < TAB_DEPTH; j++) exp_tab[j] = exp_entry(j);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_register_corners();
    test_random_rows();
    idle_pct = 0;
    stall_pct = 0;
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && context_expected.size() == 0)
      $display("tb_scaled_dot_product_attention_row_core: PASS");
    else
      $display("tb_scaled_dot_product_attention_row_core: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
